// ----- hdl/rbp_pkg.sv -----
`default_nettype none
package rbp_pkg;

  localparam int MAX_PIXELS_DEF   = 4096;
  localparam int MAX_CHANNELS_DEF = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXELS_PER_LINE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_SAMPLE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LITTLE_ENDIAN_HOST = 2'd3;

  localparam int PPL_RESET = 1024;
  localparam int CH_RESET  = 4;
  localparam int NB_RESET  = 1;
  localparam logic LE_RESET = 1'b1;

  typedef struct packed {
    logic       chunk_start;
    logic [7:0] stream_byte;
  } item_t;

  typedef struct packed {
    logic        overrun;
    logic        chunk_done;
    logic        plane_done;
    logic [11:0] first_pixel;
    logic [1:0]  plane_number;
    logic [7:0]  repeat_count;
    logic [7:0]  write_value;
    logic [16:0] write_offset;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/rbp_cfg.sv -----
`default_nettype none
module rbp_cfg
  import rbp_pkg::*;
#(
  parameter int MAX_PIXELS   = MAX_PIXELS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int PW  = $clog2(MAX_PIXELS + 1),
  localparam int CHW = $clog2(MAX_CHANNELS + 1),
  localparam int SW  = CHW + 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_valid,
  output logic                       wr_ready,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output logic [PW-1:0]              ppl,
  output logic [SW-1:0]              stride,
  output logic [2:0]                 nbytes,
  output logic                       little_endian
);

  localparam int PXW = (PW > CFG_DATA_W) ? PW : CFG_DATA_W;
  localparam int HW  = (CHW > 4) ? CHW : 4;
  localparam int PPL_RST = (MAX_PIXELS < PPL_RESET) ? MAX_PIXELS : PPL_RESET;
  localparam int CH_RST  = (MAX_CHANNELS < CH_RESET) ? MAX_CHANNELS : CH_RESET;

  logic [CHW-1:0] channels;
  logic [PW-1:0]  ppl_in;
  logic [CHW-1:0] ch_in;
  logic [2:0]     nb_in;
  logic [PXW-1:0] ppl_ext;
  logic [HW-1:0]  ch_ext;

  assign wr_ready = 1'b1;

  // clamp written values to the supported range
  always_comb begin
    ppl_ext = PXW'(wr_data);
    ch_ext  = HW'(wr_data[3:0]);
    if (wr_data == '0) begin
      ppl_in = PW'(1);
    end else if (ppl_ext > PXW'(MAX_PIXELS)) begin
      ppl_in = PW'(MAX_PIXELS);
    end else begin
      ppl_in = PW'(ppl_ext);
    end
    if (wr_data[3:0] == 4'd0) begin
      ch_in = CHW'(1);
    end else if (ch_ext > HW'(MAX_CHANNELS)) begin
      ch_in = CHW'(MAX_CHANNELS);
    end else begin
      ch_in = CHW'(ch_ext);
    end
    if (wr_data[2:0] == 3'd0) begin
      nb_in = 3'd1;
    end else if (wr_data[2:0] > 3'd4) begin
      nb_in = 3'd4;
    end else begin
      nb_in = wr_data[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ppl           <= PW'(PPL_RST);
      channels      <= CHW'(CH_RST);
      nbytes        <= 3'(NB_RESET);
      little_endian <= LE_RESET;
      stride        <= SW'(CH_RST * NB_RESET);
    end else if (wr_valid) begin
      unique case (wr_index)
        CFG_PIXELS_PER_LINE: begin
          ppl <= ppl_in;
        end
        CFG_CHANNEL_COUNT: begin
          channels <= ch_in;
          stride   <= SW'(ch_in) * SW'(nbytes);
        end
        CFG_BYTES_PER_SAMPLE: begin
          nbytes <= nb_in;
          stride <= SW'(channels) * SW'(nb_in);
        end
        CFG_LITTLE_ENDIAN_HOST: begin
          little_endian <= wr_data[0];
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/rbp_in_reg.sv -----
`default_nettype none
module rbp_in_reg
  import rbp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       held_valid,
  output item_t      held_item,
  input  wire logic  consume
);

  assign in_ready = !held_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (consume) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/rbp_decode.sv -----
`default_nettype none
module rbp_decode
  import rbp_pkg::*;
#(
  parameter int MAX_PIXELS   = MAX_PIXELS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int PW  = $clog2(MAX_PIXELS + 1),
  localparam int CHW = $clog2(MAX_CHANNELS + 1),
  localparam int SW  = CHW + 3
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  input  wire item_t         item,
  input  wire logic          slot_free,
  output logic               consume,
  output logic               res_valid,
  output result_t            res,
  input  wire logic [PW-1:0] ppl,
  input  wire logic [SW-1:0] stride,
  input  wire logic [2:0]    nbytes,
  input  wire logic          little_endian
);

  localparam int LW = (PW > 8) ? PW : 8;
  localparam int MW = 8 + SW;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_RUN,
    PH_LITERAL,
    PH_DISCARD
  } phase_t;

  phase_t      phase, c_phase, phase_next;
  logic [7:0]  lit, c_lit, lit_next;
  logic [7:0]  run, c_run, run_next;
  logic [PW-1:0] pix, c_pix, pix_next;
  logic [1:0]  plane, c_plane, plane_next;
  logic [16:0] addr, c_addr, addr_next;
  logic        fin, c_fin, fin_next;

  logic [7:0]    rest;
  logic [7:0]    want;
  logic          more;
  logic [PW-1:0] left;
  logic          cut;
  logic [7:0]    count;
  logic          pdone;
  logic [2:0]    plane_inc;
  logic          last;
  logic [MW-1:0] step;
  logic          emit;

  function automatic logic [16:0] plane_base(input logic [2:0] n, input logic le,
                                             input logic [1:0] p);
    logic [2:0] hi;
    begin
      hi = n - 3'd1 - {1'b0, p};
      return 17'(le ? hi : {1'b0, p});
    end
  endfunction

  assign consume = item_valid && slot_free;

  // state as seen by this byte, after an optional chunk restart
  always_comb begin
    if (item.chunk_start) begin
      c_phase = PH_HEADER;
      c_lit   = '0;
      c_run   = '0;
      c_pix   = '0;
      c_plane = '0;
      c_fin   = 1'b0;
      c_addr  = plane_base(nbytes, little_endian, 2'd0);
    end else begin
      c_phase = phase;
      c_lit   = lit;
      c_run   = run;
      c_pix   = pix;
      c_plane = plane;
      c_fin   = fin;
      c_addr  = addr;
    end
  end

  // write descriptor
  always_comb begin
    rest      = (c_lit != 8'd0) ? c_lit - 8'd1 : 8'd0;
    want      = (c_phase == PH_RUN) ? c_run : 8'd1;
    more      = (c_phase == PH_LITERAL) && (rest != 8'd0);
    left      = (c_pix < ppl) ? ppl - c_pix : PW'(1);
    cut       = LW'(want) > LW'(left);
    count     = cut ? 8'(left) : want;
    pdone     = LW'(count) == LW'(left);
    plane_inc = {1'b0, c_plane} + 3'd1;
    last      = plane_inc >= nbytes;
    step      = MW'(count) * MW'(stride);
  end

  always_comb begin
    phase_next = c_phase;
    lit_next   = c_lit;
    run_next   = c_run;
    pix_next   = c_pix;
    plane_next = c_plane;
    addr_next  = c_addr;
    fin_next   = c_fin;
    emit       = 1'b0;
    if (!c_fin) begin
      unique case (c_phase)
        PH_RUN: begin
          emit       = 1'b1;
          phase_next = PH_HEADER;
        end
        PH_LITERAL: begin
          emit     = 1'b1;
          lit_next = rest;
          if (rest == 8'd0) begin
            phase_next = PH_HEADER;
          end else if (pdone) begin
            phase_next = PH_DISCARD;
          end
        end
        PH_DISCARD: begin
          lit_next = rest;
          if (rest == 8'd0) begin
            phase_next = PH_HEADER;
          end
        end
        PH_HEADER: begin
          if (!item.stream_byte[7]) begin
            run_next   = item.stream_byte + 8'd1;
            phase_next = PH_RUN;
          end else begin
            lit_next   = (~item.stream_byte) + 8'd1;
            phase_next = PH_LITERAL;
          end
        end
      endcase
    end
    if (emit) begin
      if (pdone) begin
        plane_next = plane_inc[1:0];
        if (last) begin
          fin_next = 1'b1;
          pix_next = ppl;
        end else begin
          pix_next  = '0;
          addr_next = plane_base(nbytes, little_endian, plane_inc[1:0]);
        end
      end else begin
        pix_next  = c_pix + PW'(count);
        addr_next = c_addr + 17'(step);
      end
    end
  end

  always_comb begin
    res_valid        = consume && emit;
    res.write_offset = c_addr;
    res.write_value  = item.stream_byte;
    res.repeat_count = count;
    res.plane_number = c_plane;
    res.first_pixel  = 12'(c_pix);
    res.plane_done   = pdone;
    res.chunk_done   = pdone && last;
    res.overrun      = cut || (pdone && more);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      lit   <= '0;
      run   <= '0;
      pix   <= '0;
      plane <= '0;
      addr  <= '0;
      fin   <= 1'b0;
    end else if (consume) begin
      phase <= phase_next;
      lit   <= lit_next;
      run   <= run_next;
      pix   <= pix_next;
      plane <= plane_next;
      addr  <= addr_next;
      fin   <= fin_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/rbp_out_reg.sv -----
`default_nettype none
module rbp_out_reg
  import rbp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_res,
  output logic         slot_free,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_res
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/rla_byte_plane_rle_decoder.sv -----
// Byte-plane run-length decoder for channel chunks.
// s_axis: one compressed byte per transfer; tuser flags the first byte of a
//   chunk and restarts the decoder. Header bytes, literal bytes past the
//   plane end and bytes after the chunk end produce no output.
// m_axis: one write descriptor per data byte (offset, value, repeat count,
//   plane, first pixel); tlast marks the write that completes the chunk.
// cfg: register writes (index, data), always ready; write only while idle.
// Path: each byte is held in the input register, decoded, and its result
//   registered in the output register, where it is presented.
// Throughput: one byte per cycle while m_axis_tready stays high; the decode
//   state (phase, pixel index, plane, address) is computed combinationally
//   between the input register and the output register.
// Reset: configuration returns to its defaults, decoding starts at plane 0,
//   offset 0, expecting a header byte.
// Stall: while m_axis_tready is low the held result waits; one more byte
//   sits in the input register, then s_axis_tready drops.
`default_nettype none
module rla_byte_plane_rle_decoder
  import rbp_pkg::*;
#(
  parameter int MAX_PIXELS   = MAX_PIXELS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,  // stream_byte
  input  wire logic                  s_axis_tuser,  // chunk_start
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // write_offset, write_value, repeat_count, plane_number, first_pixel, pad
  output logic [47:0]                m_axis_tdata,
  output logic [1:0]                 m_axis_tuser,  // plane_done, overrun
  output logic                       m_axis_tlast,  // chunk_done
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PW  = $clog2(MAX_PIXELS + 1);
  localparam int CHW = $clog2(MAX_CHANNELS + 1);
  localparam int SW  = CHW + 3;

  logic [PW-1:0] ppl;
  logic [SW-1:0] stride;
  logic [2:0]    nbytes;
  logic          little_endian;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    consume;
  logic    slot_free;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.stream_byte = s_axis_tdata;
  assign in_item.chunk_start = s_axis_tuser;

  rbp_cfg #(
    .MAX_PIXELS   (MAX_PIXELS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .wr_valid      (cfg_valid),
    .wr_ready      (cfg_ready),
    .wr_index      (cfg_index),
    .wr_data       (cfg_data),
    .ppl           (ppl),
    .stride        (stride),
    .nbytes        (nbytes),
    .little_endian (little_endian)
  );

  rbp_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .consume    (consume)
  );

  rbp_decode #(
    .MAX_PIXELS   (MAX_PIXELS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dec (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (held_valid),
    .item          (held_item),
    .slot_free     (slot_free),
    .consume       (consume),
    .res_valid     (res_valid),
    .res           (res),
    .ppl           (ppl),
    .stride        (stride),
    .nbytes        (nbytes),
    .little_endian (little_endian)
  );

  rbp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_res  (res),
    .slot_free (slot_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.first_pixel, out_res.plane_number,
                         out_res.repeat_count, out_res.write_value, out_res.write_offset};
  assign m_axis_tuser = {out_res.overrun, out_res.plane_done};
  assign m_axis_tlast = out_res.chunk_done;

endmodule
`default_nettype wire

// ----- dv/tb_rla_byte_plane_rle_decoder.sv -----
module tb_rla_byte_plane_rle_decoder;
  import rbp_pkg::*;

  typedef enum logic [1:0] {PH_HEADER, PH_RUN, PH_LITERAL, PH_DISCARD} dec_phase_t;
  typedef enum logic [1:0] {ROW_SEND, ROW_CHECK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [12:0] arg;
    logic        cs;
    result_t     want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [47:0]           m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rla_byte_plane_rle_decoder uut (.*);

  always #2 clk = ~clk;

  // decoder model state and register copy
  logic [12:0] ppl_reg;
  logic [3:0]  ch_reg;
  logic [2:0]  nb_reg;
  logic        le_reg;
  dec_phase_t  phase;
  int          lit_left;
  int          run_len;
  int          pix_idx;
  int          plane_idx;
  logic [16:0] wr_addr;
  bit          chunk_over;

  result_t expected_writes[$];
  int      mismatch_count = 0;
  int      sent_items = 0;
  int      idle_pct = 0;
  bit      hold_req = 1'b0;
  bit      hold_rx = 1'b0;

  function automatic int clamp(int v, int hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  function automatic logic [16:0] plane_start(int p);
    logic [16:0] a;
    a = le_reg ? 17'(clamp(int'(nb_reg), 4) - 1 - p) : 17'(p);
    return a;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  function automatic result_t wr(int off, int val, int cnt, int pl, int fp,
                                 bit pd, bit cd, bit ov);
    result_t w;
    w.write_offset = 17'(off);
    w.write_value  = 8'(val);
    w.repeat_count = 8'(cnt);
    w.plane_number = 2'(pl);
    w.first_pixel  = 12'(fp);
    w.plane_done   = pd;
    w.chunk_done   = cd;
    w.overrun      = ov;
    return w;
  endfunction

  function automatic stim_row_t row_send(logic cs, logic [7:0] b);
    stim_row_t r;
    r = '0;
    r.kind = ROW_SEND;
    r.cs = cs;
    r.arg = 13'(b);
    return r;
  endfunction

  function automatic stim_row_t row_check(logic cs, logic [7:0] b, result_t w);
    stim_row_t r;
    r = row_send(cs, b);
    r.kind = ROW_CHECK;
    r.want = w;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(logic [1:0] idx, logic [12:0] d);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.arg = d;
    return r;
  endfunction

  task automatic clear_decoder();
    phase = PH_HEADER;
    lit_left = 0;
    run_len = 0;
    pix_idx = 0;
    plane_idx = 0;
    chunk_over = 1'b0;
    wr_addr = plane_start(0);
  endtask

  task automatic emit_write(input logic [7:0] value, input int want, input bit more_after,
                            output result_t w, output bit pd);
    int ppl;
    int left;
    int cnt;
    bit over;
    ppl = clamp(int'(ppl_reg), MAX_PIXELS_DEF);
    left = (pix_idx < ppl) ? ppl - pix_idx : 1;
    cnt = want;
    over = 1'b0;
    if (cnt > left) begin
      cnt = left;
      over = 1'b1;
    end
    pd = (cnt == left);
    if (pd && more_after) over = 1'b1;
    w = wr(int'(wr_addr), int'(value), cnt, plane_idx, pix_idx, pd, 1'b0, over);
    if (pd) begin
      plane_idx = plane_idx + 1;
      if (plane_idx >= clamp(int'(nb_reg), 4)) begin
        chunk_over = 1'b1;
        w.chunk_done = 1'b1;
        plane_idx = plane_idx & 3;
        pix_idx = ppl;
      end else begin
        pix_idx = 0;
        wr_addr = plane_start(plane_idx);
      end
    end else begin
      pix_idx = pix_idx + cnt;
      wr_addr = 17'(int'(wr_addr) + cnt * clamp(int'(ch_reg), MAX_CHANNELS_DEF) *
                    clamp(int'(nb_reg), 4));
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic cs,
                             output bit has, output result_t w);
    int rest;
    bit pd;
    has = 1'b0;
    w = '0;
    if (cs) clear_decoder();
    if (!chunk_over) begin
      case (phase)
        PH_RUN: begin
          phase = PH_HEADER;
          emit_write(b, run_len, 1'b0, w, pd);
          has = 1'b1;
        end
        PH_LITERAL: begin
          rest = (lit_left > 0) ? lit_left - 1 : 0;
          emit_write(b, 1, rest > 0, w, pd);
          lit_left = rest;
          if (rest == 0) phase = PH_HEADER;
          else if (pd) phase = PH_DISCARD;
          has = 1'b1;
        end
        PH_DISCARD: begin
          lit_left = (lit_left > 0) ? lit_left - 1 : 0;
          if (lit_left == 0) phase = PH_HEADER;
        end
        default: begin
          if (b < 8'd128) begin
            run_len = int'(b) + 1;
            phase = PH_RUN;
          end else begin
            lit_left = 256 - int'(b);
            phase = PH_LITERAL;
          end
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // one byte transfer, then a random gap
  task automatic send_byte(input logic [7:0] b, input logic cs, input bit typed,
                           input result_t want);
    bit has;
    result_t w;
    int gap;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= cs;
    do @(posedge clk); while (!s_axis_tready);
    decode_byte(b, cs, has, w);
    sent_items++;
    if (has) expected_writes.push_back(typed ? want : w);
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [12:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PIXELS_PER_LINE:    ppl_reg = d;
      CFG_CHANNEL_COUNT:      ch_reg = d[3:0];
      CFG_BYTES_PER_SAMPLE:   nb_reg = d[2:0];
      CFG_LITTLE_ENDIAN_HOST: le_reg = d[0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : rx_drive
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_rx || stall > 0) begin
        m_axis_tready <= 1'b0;
        if (!hold_rx) stall--;
      end else begin
        m_axis_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin : rx_hold
    wait (hold_req);
    hold_rx = 1'b1;
    repeat (300) @(posedge clk);
    hold_rx = 1'b0;
  end

  always @(posedge clk) begin : rx_check
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write descriptor %h", m_axis_tdata));
      end else begin
        want = expected_writes.pop_front();
        check_field("write_offset", int'(m_axis_tdata[16:0]), int'(want.write_offset));
        check_field("write_value", int'(m_axis_tdata[24:17]), int'(want.write_value));
        check_field("repeat_count", int'(m_axis_tdata[32:25]), int'(want.repeat_count));
        check_field("plane_number", int'(m_axis_tdata[34:33]), int'(want.plane_number));
        check_field("first_pixel", int'(m_axis_tdata[46:35]), int'(want.first_pixel));
        check_field("plane_done", int'(m_axis_tuser[0]), int'(want.plane_done));
        check_field("overrun", int'(m_axis_tuser[1]), int'(want.overrun));
        check_field("chunk_done", int'(m_axis_tlast), int'(want.chunk_done));
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("tb_rla_byte_plane_rle_decoder NOT OK");
    $finish;
  end

  initial begin : main
    stim_row_t   rows[$];
    logic [12:0] d;
    logic [7:0]  hdr;
    int          phase_no;
    int          n;
    int          r;
    int          len;
    bit          fresh;
    logic        cs;

    ppl_reg = 13'(PPL_RESET);
    ch_reg = 4'(CH_RESET);
    nb_reg = 3'(NB_RESET);
    le_reg = LE_RESET;
    phase = PH_HEADER;
    lit_left = 0;
    run_len = 0;
    pix_idx = 0;
    plane_idx = 0;
    wr_addr = '0;
    chunk_over = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults, no chunk start after reset
    rows.push_back(row_send(1'b0, 8'h00));
    rows.push_back(row_check(1'b0, 8'hAB, wr(0, 8'hAB, 1, 0, 0, 0, 0, 0)));
    rows.push_back(row_send(1'b0, 8'h7F));
    rows.push_back(row_check(1'b0, 8'hFF, wr(4, 8'hFF, 128, 0, 1, 0, 0, 0)));
    // short planes: clipped run, plane change, chunk end, trailing bytes
    rows.push_back(row_cfg(CFG_PIXELS_PER_LINE, 13'd3));
    rows.push_back(row_cfg(CFG_CHANNEL_COUNT, 13'd2));
    rows.push_back(row_cfg(CFG_BYTES_PER_SAMPLE, 13'd2));
    rows.push_back(row_cfg(CFG_LITTLE_ENDIAN_HOST, 13'd0));
    rows.push_back(row_send(1'b1, 8'h05));
    rows.push_back(row_check(1'b0, 8'h11, wr(0, 8'h11, 3, 0, 0, 1, 0, 1)));
    rows.push_back(row_send(1'b0, 8'hFD));
    rows.push_back(row_check(1'b0, 8'h22, wr(1, 8'h22, 1, 1, 0, 0, 0, 0)));
    rows.push_back(row_send(1'b0, 8'h33));
    rows.push_back(row_check(1'b0, 8'h44, wr(9, 8'h44, 1, 1, 2, 1, 1, 0)));
    rows.push_back(row_send(1'b0, 8'h00));
    rows.push_back(row_send(1'b0, 8'h12));
    // literal past plane end, rest discarded
    rows.push_back(row_send(1'b1, 8'hFB));
    rows.push_back(row_send(1'b0, 8'h01));
    rows.push_back(row_send(1'b0, 8'h02));
    rows.push_back(row_check(1'b0, 8'h03, wr(8, 8'h03, 1, 0, 2, 1, 0, 1)));
    rows.push_back(row_send(1'b0, 8'h04));
    rows.push_back(row_send(1'b0, 8'h05));
    // plane length cut below pixel index mid-chunk
    rows.push_back(row_cfg(CFG_PIXELS_PER_LINE, 13'd20));
    rows.push_back(row_cfg(CFG_CHANNEL_COUNT, 13'd1));
    rows.push_back(row_cfg(CFG_BYTES_PER_SAMPLE, 13'd1));
    rows.push_back(row_send(1'b1, 8'h09));
    rows.push_back(row_send(1'b0, 8'h01));
    rows.push_back(row_cfg(CFG_PIXELS_PER_LINE, 13'd5));
    rows.push_back(row_send(1'b0, 8'h02));
    rows.push_back(row_send(1'b0, 8'h77));
    // registers below range
    rows.push_back(row_cfg(CFG_PIXELS_PER_LINE, 13'd0));
    rows.push_back(row_cfg(CFG_CHANNEL_COUNT, 13'd0));
    rows.push_back(row_cfg(CFG_BYTES_PER_SAMPLE, 13'd0));
    rows.push_back(row_cfg(CFG_LITTLE_ENDIAN_HOST, 13'd1));
    rows.push_back(row_send(1'b1, 8'h80));
    rows.push_back(row_check(1'b0, 8'h5A, wr(0, 8'h5A, 1, 0, 0, 1, 1, 1)));
    // registers above range
    rows.push_back(row_cfg(CFG_PIXELS_PER_LINE, 13'd8191));
    rows.push_back(row_cfg(CFG_CHANNEL_COUNT, 13'd15));
    rows.push_back(row_cfg(CFG_BYTES_PER_SAMPLE, 13'd7));
    rows.push_back(row_send(1'b1, 8'h7F));
    rows.push_back(row_check(1'b0, 8'hC3, wr(3, 8'hC3, 128, 0, 0, 0, 0, 0)));

    idle_pct = 30;
    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_CFG: begin
          drain();
          cfg_write(rows[i].idx, rows[i].arg);
        end
        ROW_CHECK: send_byte(rows[i].arg[7:0], rows[i].cs, 1'b1, rows[i].want);
        default:   send_byte(rows[i].arg[7:0], rows[i].cs, 1'b0, '0);
      endcase
    end

    phase_no = 0;
    while (sent_items < 545) begin
      drain();
      d = 13'($urandom);
      case ($urandom_range(0, 9))
        0: d = 13'd1;
        1: d = 13'd4096;
        2: d = 13'd0;
        3: d = 13'd8191;
        4: d = 13'd4097;
        default: d = 13'($urandom_range(1, 24));
      endcase
      cfg_write(CFG_PIXELS_PER_LINE, d);
      d = 13'($urandom);
      d[3:0] = 4'($urandom_range(0, 15));
      cfg_write(CFG_CHANNEL_COUNT, d);
      d = 13'($urandom);
      d[2:0] = 3'($urandom_range(0, 7));
      cfg_write(CFG_BYTES_PER_SAMPLE, d);
      d = 13'($urandom);
      cfg_write(CFG_LITTLE_ENDIAN_HOST, d);

      case (phase_no % 3)
        0: idle_pct = 0;
        1: idle_pct = 25;
        default: idle_pct = 60;
      endcase
      if (phase_no == 0) begin
        idle_pct = 0;
        hold_req = 1'b1;
      end

      fresh = ($urandom_range(0, 3) != 0);
      n = $urandom_range(8, 30);
      for (int k = 0; k < n && sent_items < 545; k++) begin
        r = $urandom_range(0, 99);
        cs = fresh || (chunk_over && $urandom_range(0, 3) != 0);
        fresh = 1'b0;
        if (r < 10) begin
          send_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'b0, '0);
        end else if (r < 55) begin
          hdr = ($urandom_range(0, 15) == 0) ? 8'h7F : 8'($urandom_range(0, 15));
          send_byte(hdr, cs, 1'b0, '0);
          send_byte(8'($urandom), 1'b0, 1'b0, '0);
        end else begin
          len = ($urandom_range(0, 19) == 0) ? 128 : $urandom_range(1, 6);
          hdr = 8'(256 - len);
          send_byte(hdr, cs, 1'b0, '0);
          repeat (len) send_byte(8'($urandom), 1'b0, 1'b0, '0);
        end
      end
      phase_no++;
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_writes.size() == 0) begin
      $display("tb_rla_byte_plane_rle_decoder OK");
    end else begin
      $display("tb_rla_byte_plane_rle_decoder NOT OK");
    end
    $finish;
  end

endmodule
